/* hdl/kmeq_pkg.sv */
// Shared types, constants and helpers for the key matrix event queue.
package kmeq_pkg;

   localparam int NUM_ROWS_C   = 11;
   localparam int NUM_COLS_C   = 12;
   localparam int RING_DEPTH_C = 64;

   localparam int ROW_W_C   = 4;
   localparam int COL_W_C   = 4;
   localparam int KEY_W_C   = 8;
   localparam int PAT_W_C   = 12;
   localparam int ENTRY_W_C = 9;

   localparam logic [ROW_W_C-1:0] LAST_ROW_C = 4'd10;
   localparam logic [COL_W_C-1:0] LAST_COL_C = 4'd11;
   localparam logic [KEY_W_C-1:0] ROW_STEP_C = 8'd12;

   // Item kinds carried in the mode flag
   localparam logic MODE_SAMPLE_C = 1'b0;
   localparam logic MODE_POP_C    = 1'b1;

   typedef logic [PAT_W_C-1:0]   pattern_type;
   typedef logic [ROW_W_C-1:0]   row_type;
   typedef logic [ENTRY_W_C-1:0] entry_type;

   // Commands to the row pattern memories
   typedef struct packed {
      logic        rd_en;
      row_type     addr;
      logic        first_we;
      pattern_type first_data;
      logic        stable_we;
      pattern_type stable_data;
   } scan_cmd_type;

   // Commands to the event ring
   typedef struct packed {
      logic      push;
      entry_type entry;
      logic      pop;
   } ring_cmd_type;

   // Raw active-low levels (column c on bit 11-c) to pressed pattern (bit c)
   function automatic pattern_type to_pattern(input logic [PAT_W_C-1:0] raw);
      pattern_type p;
      for (int c = 0; c < PAT_W_C; c++) begin
         p[c] = ~raw[PAT_W_C-1-c];
      end
      return p;
   endfunction

endpackage

/* hdl/kmeq_scan_store.sv */
// Row pattern memories: first pass scan and last stable key state.
module kmeq_scan_store (
   input  logic                  clock,
   input  logic                  reset,
   input  kmeq_pkg::scan_cmd_type cmd,
   output kmeq_pkg::pattern_type first_rd,
   output kmeq_pkg::pattern_type stable_rd
);
   import kmeq_pkg::*;

   pattern_type           first_mem  [NUM_ROWS_C];
   pattern_type           stable_mem [NUM_ROWS_C];
   pattern_type           first_rd_ff;
   pattern_type           stable_rd_ff;
   logic [NUM_ROWS_C-1:0] stable_vld_ff;

   // First pass memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.first_we) begin
         first_mem[cmd.addr] <= cmd.first_data;
      end
      if (cmd.rd_en) begin
         first_rd_ff <= first_mem[cmd.addr];
      end
   end

   // Per-row written flags: rows never committed read as no key pressed
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_vld_ff <= '0;
      end else if (cmd.stable_we) begin
         stable_vld_ff[cmd.addr] <= 1'b1;
      end
   end

   // Stable state memory, shares the address
   always_ff @(posedge clock) begin
      if (cmd.stable_we) begin
         stable_mem[cmd.addr] <= cmd.stable_data;
      end
      if (cmd.rd_en) begin
         stable_rd_ff <= stable_vld_ff[cmd.addr] ? stable_mem[cmd.addr] : '0;
      end
   end

   assign first_rd  = first_rd_ff;
   assign stable_rd = stable_rd_ff;

endmodule

/* hdl/kmeq_event_ring.sv */
// Event ring: memory with head and tail pointers, drops pushes when full.
module kmeq_event_ring #(
   parameter int DEPTH_P = kmeq_pkg::RING_DEPTH_C
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kmeq_pkg::ring_cmd_type cmd,
   output logic                   empty,
   output kmeq_pkg::entry_type    rd_data
);
   import kmeq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH_P);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH_P - 1);

   entry_type        ring_mem [DEPTH_P];
   entry_type        rd_data_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic             full;
   logic             do_push;
   logic             do_pop;

   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
   assign empty     = (head_ff == tail_ff);
   assign full      = (tail_next == head_ff);
   assign do_push   = cmd.push & ~full;
   assign do_pop    = cmd.pop & ~empty;

   // Pointer update
   always_comb begin
      head_in = do_pop  ? head_next : head_ff;
      tail_in = do_push ? tail_next : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Ring storage, registered read at the head
   always_ff @(posedge clock) begin
      if (do_push) begin
         ring_mem[tail_ff] <= cmd.entry;
      end
      if (do_pop) begin
         rd_data_ff <= ring_mem[head_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/key_matrix_event_queue.sv */
// Key matrix event queue top level: item sequencer, commit walk, result register.
// Takes row samples of an 11x12 key matrix in pairs of passes and pop requests, one
// item at a time. A first-pass sample or an out-of-range row is taken in the idle
// state; a second-pass sample adds a registered read of the stored first-pass row
// and a compare. The row 10 second-pass sample of an agreeing pair then walks the
// pattern memories row by row (one read, then one column per cycle, each column
// writing at most one ring entry) through the whole matrix, during which req_tready
// is low. A pop reads the ring memory, then loads the result register once any beat
// still held there has been taken on rsp_tready. Every pop returns one beat; on an
// empty ring its event_valid is 0. The ring holds RING_DEPTH_P-1 events; events that
// find it full are dropped.
module key_matrix_event_queue #(
   parameter int RING_DEPTH_P = kmeq_pkg::RING_DEPTH_C
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] row, [15:4] columns
   input  logic [1:0]  req_tuser,   // [0] mode, [1] pass_second
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] key_index
   output logic [1:0]  rsp_tuser    // [0] event_valid, [1] event_pressed
);
   import kmeq_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CMP    = 3'd1;
   localparam logic [2:0] ST_POP    = 3'd2;
   localparam logic [2:0] ST_ROW_RD = 3'd3;
   localparam logic [2:0] ST_COL    = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic               mismatch_ff, mismatch_in;
   pattern_type        pat_ff, pat_in;
   row_type            row_ff, row_in;
   logic [COL_W_C-1:0] col_ff, col_in;
   logic [KEY_W_C-1:0] base_ff, base_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_pressed_ff, rsp_pressed_in;
   logic [KEY_W_C-1:0] rsp_key_ff, rsp_key_in;

   scan_cmd_type scan_cmd;
   ring_cmd_type ring_cmd;
   pattern_type  first_rd;
   pattern_type  stable_rd;
   pattern_type  sample_pat;
   entry_type    ring_rd;
   logic         ring_empty;
   logic         accept;
   logic         in_mode;
   logic         in_second;
   row_type      in_row;
   logic         mismatch_now;
   logic         next_bit;
   logic         last_bit;

   assign in_row     = req_tdata[3:0];
   assign in_mode    = req_tuser[0];
   assign in_second  = req_tuser[1];
   assign sample_pat = to_pattern(req_tdata[15:4]);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   assign mismatch_now = mismatch_ff | (first_rd != pat_ff);
   assign next_bit     = first_rd[col_ff];
   assign last_bit     = stable_rd[col_ff];

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      mismatch_in    = mismatch_ff;
      pat_in         = pat_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      base_in        = base_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_key_in     = rsp_key_ff;

      scan_cmd             = '0;
      scan_cmd.addr        = row_ff;
      scan_cmd.first_data  = sample_pat;
      scan_cmd.stable_data = first_rd;
      ring_cmd             = '0;
      ring_cmd.entry       = {next_bit, base_ff + KEY_W_C'(col_ff)};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_mode == MODE_POP_C) begin
                  hit_in       = ~ring_empty;
                  ring_cmd.pop = 1'b1;
                  state_in     = ST_POP;
               end else if (in_row <= LAST_ROW_C) begin
                  scan_cmd.addr = in_row;
                  if (!in_second) begin
                     scan_cmd.first_we = 1'b1;
                  end else begin
                     scan_cmd.rd_en = 1'b1;
                     pat_in         = sample_pat;
                     row_in         = in_row;
                     state_in       = ST_CMP;
                  end
               end
            end
         end
         ST_CMP: begin
            if (row_ff == LAST_ROW_C) begin
               mismatch_in = 1'b0;
               if (mismatch_now) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = '0;
                  base_in  = '0;
                  state_in = ST_ROW_RD;
               end
            end else begin
               mismatch_in = mismatch_now;
               state_in    = ST_IDLE;
            end
         end
         ST_POP: begin
            // Empty ring still answers, with event_valid low
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = hit_ff;
               rsp_pressed_in = hit_ff & ring_rd[KEY_W_C];
               rsp_key_in     = hit_ff ? ring_rd[KEY_W_C-1:0] : '0;
               state_in       = ST_IDLE;
            end
         end
         ST_ROW_RD: begin
            scan_cmd.rd_en = 1'b1;
            col_in         = '0;
            state_in       = ST_COL;
         end
         ST_COL: begin
            // One changed key at most per column: release and press exclude
            ring_cmd.push = next_bit ^ last_bit;
            col_in        = col_ff + 1'b1;
            if (col_ff == LAST_COL_C) begin
               scan_cmd.stable_we = 1'b1;
               row_in             = row_ff + 1'b1;
               base_in            = base_ff + ROW_STEP_C;
               state_in           = (row_ff == LAST_ROW_C) ? ST_IDLE : ST_ROW_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mismatch_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mismatch_ff  <= mismatch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      pat_ff         <= pat_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      base_ff        <= base_in;
      hit_ff         <= hit_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_key_ff     <= rsp_key_in;
   end

   kmeq_scan_store u_scan_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (scan_cmd),
      .first_rd  (first_rd),
      .stable_rd (stable_rd)
   );

   kmeq_event_ring #(
      .DEPTH_P (RING_DEPTH_P)
   ) u_event_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .empty   (ring_empty),
      .rd_data (ring_rd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tuser  = {rsp_pressed_ff, rsp_hit_ff};

endmodule

/* tb/sv/tb_key_matrix_event_queue.sv */
// Self-checking testbench for key_matrix_event_queue: scan pairs and pops against a behavioral model.
`timescale 1ns / 100ps

module tb_key_matrix_event_queue;
   import kmeq_pkg::*;

   localparam logic PASS_FIRST   = 1'b0;
   localparam logic PASS_SECOND  = 1'b1;
   localparam int   NUM_ITEMS    = 600;
   localparam int   TAIL_ITEMS   = 60;
   localparam int   DRAIN_CYCLES = 300;
   localparam int   CYCLE_LIMIT  = 400000;
   localparam int   RING_CAP     = RING_DEPTH_C - 1;
   localparam logic [PAT_W_C-1:0] ALL_UP   = 12'hFFF;
   localparam logic [PAT_W_C-1:0] ALL_DOWN = 12'h000;

   // One input beat: kind, pass, row and raw active-low column levels
   typedef struct packed {
      logic        mode;
      logic        second;
      row_type     row;
      pattern_type levels;
   } scan_item_type;

   // One popped event as the block reports it
   typedef struct packed {
      logic               valid;
      logic               pressed;
      logic [KEY_W_C-1:0] key;
   } key_event_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [3:0] row, [15:4] columns
   logic [1:0]  req_tuser  = '0;   // [0] mode, [1] pass_second
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] key_index
   logic [1:0]  rsp_tuser;         // [0] event_valid, [1] event_pressed

   scan_item_type  pending_items[$];
   key_event_type  expected_events[$];

   // Model of the block: pass buffers, committed keys, event backlog
   entry_type   event_backlog[$];
   pattern_type first_pat[NUM_ROWS_C]  = '{default: '0};
   pattern_type stable_pat[NUM_ROWS_C] = '{default: '0};
   logic        pair_bad = 1'b0;

   // Stimulus builder state
   pattern_type levels_now[NUM_ROWS_C];
   bit          rows_written[NUM_ROWS_C] = '{default: 1'b0};
   int          counted = 0;

   bit            failed = 1'b0;
   int unsigned   cycles = 0;
   int            send_gap = 0;
   int            stall_left = 0;
   scan_item_type next_item;
   key_event_type want;

   key_matrix_event_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Queue an event unless the ring is already full
   function automatic void queue_event(input entry_type ev);
      if (event_backlog.size() < RING_CAP) event_backlog.push_back(ev);
   endfunction

   // Advance the model by one accepted beat; pops produce an expected event
   function automatic void track_item(input scan_item_type it);
      pattern_type        seen;
      pattern_type        nxt;
      pattern_type        last;
      key_event_type      res;
      entry_type          ev;
      logic [KEY_W_C-1:0] key;
      if (it.mode == MODE_POP_C) begin
         res = '0;
         if (event_backlog.size() != 0) begin
            ev          = event_backlog.pop_front();
            res.valid   = 1'b1;
            res.pressed = ev[ENTRY_W_C-1];
            res.key     = ev[KEY_W_C-1:0];
         end
         expected_events.push_back(res);
         return;
      end
      if (it.row > LAST_ROW_C) return;
      // column c sits on bit 11-c and reads low when pressed
      for (int c = 0; c < PAT_W_C; c++) seen[c] = ~it.levels[PAT_W_C-1-c];
      if (it.second == PASS_FIRST) begin
         first_pat[it.row] = seen;
         return;
      end
      if (seen != first_pat[it.row]) pair_bad = 1'b1;
      if (it.row == LAST_ROW_C) begin
         if (!pair_bad) begin
            // walk keys in order; a key gives a release or a press, never both
            for (int r = 0; r < NUM_ROWS_C; r++) begin
               nxt  = first_pat[r];
               last = stable_pat[r];
               for (int c = 0; c < NUM_COLS_C; c++) begin
                  key = KEY_W_C'(r * NUM_COLS_C + c);
                  if (last[c] && !nxt[c]) queue_event({1'b0, key});
                  if (nxt[c] && !last[c]) queue_event({1'b1, key});
               end
               stable_pat[r] = nxt;
            end
         end
         pair_bad = 1'b0;
      end
   endfunction

   // Stimulus helpers: plain beat, random pop, random noise beat, full scan pair
   task automatic add_item(input logic mode, input logic second, input row_type row,
                           input pattern_type levels);
      scan_item_type it;
      it = '{mode: mode, second: second, row: row, levels: levels};
      pending_items.push_back(it);
      if (mode == MODE_POP_C || row <= LAST_ROW_C) counted++;
      if (mode == MODE_SAMPLE_C && second == PASS_FIRST && row <= LAST_ROW_C)
         rows_written[row] = 1'b1;
   endtask

   task automatic add_pop();
      add_item(MODE_POP_C, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
               12'($urandom_range(0, 4095)));
   endtask

   task automatic add_noise();
      logic    second;
      row_type row;
      second = 1'($urandom_range(0, 1));
      row    = 4'($urandom_range(0, 15));
      // never compare against a first-pass row that has not been stored yet
      if (second == PASS_SECOND && row <= LAST_ROW_C && !rows_written[row])
         second = PASS_FIRST;
      add_item(1'($urandom_range(0, 1)), second, row, 12'($urandom_range(0, 4095)));
   endtask

   task automatic add_pair(input bit corrupt);
      int          bad_row;
      pattern_type lv;
      bad_row = corrupt ? $urandom_range(0, NUM_ROWS_C - 1) : -1;
      for (int r = 0; r < NUM_ROWS_C; r++) begin
         if ($urandom_range(0, 9) == 0) add_pop();
         add_item(MODE_SAMPLE_C, PASS_FIRST, 4'(r), levels_now[r]);
      end
      for (int r = 0; r < NUM_ROWS_C; r++) begin
         if ($urandom_range(0, 9) == 0) add_pop();
         lv = levels_now[r];
         if (r == bad_row) lv[$urandom_range(0, PAT_W_C - 1)] ^= 1'b1;
         add_item(MODE_SAMPLE_C, PASS_SECOND, 4'(r), lv);
      end
   endtask

   // Stimulus, reset and end of run
   initial begin
      int pick;
      int rr;
      int cc;
      // directed: pop on empty, out-of-range rows, every key pressed (ring overflow)
      add_item(MODE_POP_C, PASS_FIRST, 4'd0, ALL_DOWN);
      add_item(MODE_SAMPLE_C, PASS_FIRST, 4'd15, ALL_DOWN);
      add_item(MODE_SAMPLE_C, PASS_SECOND, 4'd11, ALL_UP);
      for (int r = 0; r < NUM_ROWS_C; r++) levels_now[r] = ALL_DOWN;
      for (int r = 0; r < NUM_ROWS_C; r++)
         add_item(MODE_SAMPLE_C, PASS_FIRST, 4'(r), levels_now[r]);
      for (int r = 0; r < NUM_ROWS_C; r++)
         add_item(MODE_SAMPLE_C, PASS_SECOND, 4'(r), levels_now[r]);
      add_item(MODE_POP_C, PASS_SECOND, 4'd15, ALL_UP);
      add_item(MODE_POP_C, PASS_FIRST, 4'd10, ALL_DOWN);
      counted = 0;

      // random: mostly well-formed scan pairs with drifting keys, plus pops and noise
      for (int r = 0; r < NUM_ROWS_C; r++) levels_now[r] = ALL_UP;
      add_pair(1'b0);
      while (counted < NUM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            if ($urandom_range(0, 11) == 0) begin
               for (int r = 0; r < NUM_ROWS_C; r++)
                  levels_now[r] = $urandom_range(0, 1) ? ALL_UP : ALL_DOWN;
            end else begin
               repeat ($urandom_range(0, 3)) begin
                  rr = $urandom_range(0, NUM_ROWS_C - 1);
                  cc = $urandom_range(0, PAT_W_C - 1);
                  levels_now[rr][cc] = ~levels_now[rr][cc];
               end
            end
            add_pair($urandom_range(0, 4) == 0);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 8)) add_pop();
         end else begin
            repeat ($urandom_range(1, 4)) add_noise();
         end
      end
      repeat (40) add_pop();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("tb_key_matrix_event_queue: PASS");
      end else begin
         $display("tb_key_matrix_event_queue: FAIL");
      end
      $finish;
   end

   // Request driver: holds a beat until taken, random gaps except near the end
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
         // beat still waiting
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_items.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
         send_gap = $urandom_range(1, 15) - 1;
         req_tvalid <= 1'b0;
      end else begin
         next_item = pending_items.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= {next_item.second, next_item.mode};
         req_tdata  <= {next_item.levels, next_item.row};
      end
   end

   // Response back-pressure: random stall bursts except near the end
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (pending_items.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Model update on every accepted request beat
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         track_item({req_tuser[0], req_tuser[1], req_tdata[3:0], req_tdata[15:4]});
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected result beat: valid=%0b pressed=%0b key=%0d",
                     $time, rsp_tuser[0], rsp_tuser[1], rsp_tdata);
            failed = 1'b1;
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser[0] !== want.valid) begin
               $display("%0t: event_valid expected %0b, got %0b",
                        $time, want.valid, rsp_tuser[0]);
               failed = 1'b1;
            end
            if (rsp_tuser[1] !== want.pressed) begin
               $display("%0t: event_pressed expected %0b, got %0b",
                        $time, want.pressed, rsp_tuser[1]);
               failed = 1'b1;
            end
            if (rsp_tdata !== want.key) begin
               $display("%0t: key_index expected %0d, got %0d", $time, want.key, rsp_tdata);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_key_matrix_event_queue: FAIL");
         $finish;
      end
   end

endmodule

/* files.f */
hdl/kmeq_pkg.sv
hdl/kmeq_scan_store.sv
hdl/kmeq_event_ring.sv
hdl/key_matrix_event_queue.sv
tb/sv/tb_key_matrix_event_queue.sv
